// ===== hdl/ibmw_pkg.sv =====
// Shared types and constants for the inode block map walker.
`timescale 1ns / 1ps

package ibmw_pkg;

  localparam int DIRECT_POINTERS = 5;
  localparam int PTR_IDX_W       = 5;
  localparam int PTRS_PER_BLOCK  = 1 << PTR_IDX_W;
  localparam int BLOCK_W         = 16;
  localparam int ADDR_W          = 32;
  localparam int OFFSET_W        = 2 * PTR_IDX_W;
  localparam int DIRECT_IDX_W    = $clog2(DIRECT_POINTERS);

  localparam int S_DATA_W = 304;
  localparam int M_DATA_W = 40;

  // Pointer words still to fetch after the one being requested.
  localparam logic [1:0] LEVEL_LAST     = 2'd0;
  localparam logic [1:0] LEVEL_ONE_MORE = 2'd1;
  localparam logic [1:0] LEVEL_TWO_MORE = 2'd2;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_WORD  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_RANGE = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  typedef struct packed {
    cmd_t                                   command;
    logic [BLOCK_W-1:0]                     block_index;
    logic [DIRECT_POINTERS-1:0][ADDR_W-1:0] direct;
    logic [ADDR_W-1:0]                      single_indirect;
    logic [ADDR_W-1:0]                      double_indirect;
    logic [ADDR_W-1:0]                      triple_indirect;
    logic [ADDR_W-1:0]                      read_word;
  } item_t;

  typedef struct packed {
    logic                active;
    logic [1:0]          levels;
    logic [OFFSET_W-1:0] offset;
  } walk_state_t;

  typedef struct packed {
    kind_t                kind;
    logic [ADDR_W-1:0]    address;
    logic [PTR_IDX_W-1:0] word_index;
  } result_t;

endpackage

// ===== hdl/ibmw_in_stage.sv =====
// Input register stage: unpacks the slave word and holds it until the walk step takes it.
`timescale 1ns / 1ps

module ibmw_in_stage (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [ibmw_pkg::S_DATA_W-1:0] s_axis_tdata,
  input  logic                     s_axis_tuser,
  input  logic                     advance,
  output logic                     item_valid,
  output ibmw_pkg::item_t          item
);
  import ibmw_pkg::*;

  item_t unpacked;

  always_comb begin
    unpacked.command         = cmd_t'(s_axis_tuser);
    unpacked.block_index     = s_axis_tdata[15:0];
    unpacked.direct[0]       = s_axis_tdata[47:16];
    unpacked.direct[1]       = s_axis_tdata[79:48];
    unpacked.direct[2]       = s_axis_tdata[111:80];
    unpacked.direct[3]       = s_axis_tdata[143:112];
    unpacked.direct[4]       = s_axis_tdata[175:144];
    unpacked.single_indirect = s_axis_tdata[207:176];
    unpacked.double_indirect = s_axis_tdata[239:208];
    unpacked.triple_indirect = s_axis_tdata[271:240];
    unpacked.read_word       = s_axis_tdata[303:272];
  end

  assign s_axis_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_axis_tready) begin
      item_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item <= unpacked;
    end
  end

endmodule

// ===== hdl/ibmw_walk_step.sv =====
// One walk step: range decode of a start or one level down on a returned pointer word.
`timescale 1ns / 1ps

module ibmw_walk_step (
  input  ibmw_pkg::item_t       item,
  input  ibmw_pkg::walk_state_t walk,
  output ibmw_pkg::walk_state_t walk_next,
  output ibmw_pkg::result_t     res
);
  import ibmw_pkg::*;

  localparam logic [BLOCK_W-1:0] SINGLE_BASE = BLOCK_W'(DIRECT_POINTERS);
  localparam logic [BLOCK_W-1:0] DOUBLE_BASE = BLOCK_W'(DIRECT_POINTERS + PTRS_PER_BLOCK);
  localparam logic [BLOCK_W-1:0] TRIPLE_BASE =
    BLOCK_W'(DIRECT_POINTERS + PTRS_PER_BLOCK + PTRS_PER_BLOCK * PTRS_PER_BLOCK);
  localparam logic [BLOCK_W-1:0] TRIPLE_END  =
    BLOCK_W'(DIRECT_POINTERS + PTRS_PER_BLOCK + PTRS_PER_BLOCK * PTRS_PER_BLOCK
             + PTRS_PER_BLOCK * PTRS_PER_BLOCK * PTRS_PER_BLOCK);

  logic [BLOCK_W-1:0] b;
  logic [BLOCK_W-1:0] rel_single;
  logic [BLOCK_W-1:0] rel_double;
  logic [BLOCK_W-1:0] rel_triple;

  always_comb begin
    b          = item.block_index;
    rel_single = b - SINGLE_BASE;
    rel_double = b - DOUBLE_BASE;
    rel_triple = b - TRIPLE_BASE;

    walk_next      = walk;
    res.kind       = KIND_IDLE;
    res.address    = '0;
    res.word_index = '0;

    if (item.command == CMD_START) begin
      // a start always drops any walk in flight
      walk_next.active = 1'b0;
      walk_next.levels = LEVEL_LAST;
      walk_next.offset = '0;
      if (b < SINGLE_BASE) begin
        res.kind    = KIND_DONE;
        res.address = item.direct[b[DIRECT_IDX_W-1:0]];
      end else if (b < DOUBLE_BASE) begin
        walk_next.active = 1'b1;
        res.kind         = KIND_READ;
        res.address      = item.single_indirect;
        res.word_index   = rel_single[PTR_IDX_W-1:0];
      end else if (b < TRIPLE_BASE) begin
        walk_next.active = 1'b1;
        walk_next.levels = LEVEL_ONE_MORE;
        walk_next.offset = OFFSET_W'(rel_double[PTR_IDX_W-1:0]);
        res.kind         = KIND_READ;
        res.address      = item.double_indirect;
        res.word_index   = rel_double[2*PTR_IDX_W-1:PTR_IDX_W];
      end else if (b < TRIPLE_END) begin
        walk_next.active = 1'b1;
        walk_next.levels = LEVEL_TWO_MORE;
        walk_next.offset = rel_triple[OFFSET_W-1:0];
        res.kind         = KIND_READ;
        res.address      = item.triple_indirect;
        res.word_index   = rel_triple[3*PTR_IDX_W-1:2*PTR_IDX_W];
      end else begin
        res.kind = KIND_RANGE;
      end
    end else if (walk.active) begin
      res.address = item.read_word;
      if (walk.levels == LEVEL_LAST) begin
        walk_next.active = 1'b0;
        walk_next.offset = '0;
        res.kind         = KIND_DONE;
      end else if (walk.levels == LEVEL_ONE_MORE) begin
        walk_next.levels = LEVEL_LAST;
        walk_next.offset = '0;
        res.kind         = KIND_READ;
        res.word_index   = walk.offset[PTR_IDX_W-1:0];
      end else begin
        walk_next.levels = LEVEL_ONE_MORE;
        walk_next.offset = OFFSET_W'(walk.offset[PTR_IDX_W-1:0]);
        res.kind         = KIND_READ;
        res.word_index   = walk.offset[2*PTR_IDX_W-1:PTR_IDX_W];
      end
    end
  end

endmodule

// ===== hdl/inode_block_map_walker_unit.sv =====
// Top level of the inode block map walker: input stage, walk state, result register.
`timescale 1ns / 1ps
//
// Maps a logical block number of a file to a data block address through an
// inode map of five direct pointers and single, double and triple indirect
// pointer blocks of 32 words each.
// Slave channel: tuser is the command (start, or pointer word returned);
// tdata carries block number, inode pointers and the returned word.
// Master channel: tuser is the result kind (read pointer word, done, out of
// range, not busy); tdata carries the address and the word index to read.
// Every accepted slave word yields exactly one master word.
// An accepted word passes the input register, then the result register,
// which raises master tvalid. Throughput: one word per cycle while the
// receiver does not stall; the walk state update is a range compare and
// bit slicing between the two registers, so back-to-back words see the
// state left by the previous one.
// Reset clears both stage valids and the walk state (idle, no walk).
// When the receiver stalls, the result register holds, the input register
// fills, and slave tready drops only once both are occupied.
//
module inode_block_map_walker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] block_index, [47:16] direct_0, [79:48] direct_1, [111:80] direct_2,
  // [143:112] direct_3, [175:144] direct_4, [207:176] single_indirect,
  // [239:208] double_indirect, [271:240] triple_indirect, [303:272] read_word
  input  logic [303:0] s_axis_tdata,
  // [0] command
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] address, [36:32] word_index, [39:37] zero
  output logic [39:0] m_axis_tdata,
  // [1:0] kind
  output logic [1:0]  m_axis_tuser
);
  import ibmw_pkg::*;

  logic        advance;
  logic        item_valid;
  item_t       item;
  walk_state_t walk;
  walk_state_t walk_next;
  result_t     step_res;
  result_t     res;

  // advance the pipe whenever the result register is free or being drained
  assign advance = !m_axis_tvalid || m_axis_tready;

  ibmw_in_stage u_in (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .advance       (advance),
    .item_valid    (item_valid),
    .item          (item)
  );

  ibmw_walk_step u_step (
    .item      (item),
    .walk      (walk),
    .walk_next (walk_next),
    .res       (step_res)
  );

  // walk state moves only when an item is consumed
  always_ff @(posedge clk) begin
    if (rst) begin
      walk <= '0;
    end else if (item_valid && advance) begin
      walk <= walk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= item_valid;
    end
  end

  // hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (item_valid && advance) begin
      res <= step_res;
    end
  end

  assign m_axis_tdata = {(M_DATA_W - ADDR_W - PTR_IDX_W)'(0), res.word_index, res.address};
  assign m_axis_tuser = res.kind;

endmodule

// ===== hdl/ibmw_checker.sv =====
// Port-level checks for the inode block map walker, bound to the top level.
`timescale 1ns / 1ps

module ibmw_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);
  import ibmw_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("master valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_index_only_on_read: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != KIND_READ |-> m_axis_tdata[36:32] == 5'd0)
    else $error("word index set on a non-read result");

  a_no_address_on_fault: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_RANGE || m_axis_tuser == KIND_IDLE)
      |-> m_axis_tdata[31:0] == 32'd0)
    else $error("address set on out-of-range or not-busy result");

endmodule

bind inode_block_map_walker_unit ibmw_checker u_ibmw_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_inode_block_map_walker_unit.sv =====
// Testbench for the inode block map walker: directed and random walks against a predictor.
`timescale 1ns / 1ps

module tb_inode_block_map_walker_unit;
  import ibmw_pkg::*;

  // Logical block ranges of the map, first block of each region.
  localparam int FIRST_SINGLE = DIRECT_POINTERS;
  localparam int FIRST_DOUBLE = FIRST_SINGLE + PTRS_PER_BLOCK;
  localparam int FIRST_TRIPLE = FIRST_DOUBLE + PTRS_PER_BLOCK * PTRS_PER_BLOCK;
  localparam int LAST_MAPPED  = FIRST_TRIPLE + PTRS_PER_BLOCK * PTRS_PER_BLOCK * PTRS_PER_BLOCK - 1;
  localparam int BLOCK_MAX    = (1 << BLOCK_W) - 1;

  localparam int RANDOM_WORDS   = 1000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 8;
  // Worst case per word: sender gap plus receiver stall.
  localparam int CYCLE_LIMIT    = 400000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [303:0]  s_axis_tdata = '0;
  logic          s_axis_tuser = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [39:0]   m_axis_tdata;
  logic [1:0]    m_axis_tuser;

  inode_block_map_walker_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor copy of the walk state.
  logic        walk_busy   = 1'b0;
  logic [1:0]  walk_levels = LEVEL_LAST;
  logic [14:0] walk_offset = '0;

  // Answers the block owes, oldest first.
  result_t answers_due[$];

  int error_count = 0;
  int words_sent = 0;
  int answers_checked = 0;
  int kind_seen[4] = '{0, 0, 0, 0};

  // Sender burst bookkeeping.
  int burst_left = 0;

  // Receiver hold-off request; picked up and counted down by the receiver.
  int hold_request = 0;

  // Advance the predicted walk by one accepted word and return its answer.
  function automatic result_t map_walk(input item_t it);
    result_t r;
    int      blk;
    int      rel;
    r.kind       = KIND_IDLE;
    r.address    = '0;
    r.word_index = '0;
    if (it.command == CMD_START) begin
      // A start always drops whatever walk was in flight.
      walk_busy   = 1'b0;
      walk_levels = LEVEL_LAST;
      walk_offset = '0;
      blk = int'(it.block_index);
      if (blk < FIRST_SINGLE) begin
        r.kind    = KIND_DONE;
        r.address = it.direct[blk];
      end else if (blk < FIRST_DOUBLE) begin
        walk_busy    = 1'b1;
        r.kind       = KIND_READ;
        r.address    = it.single_indirect;
        r.word_index = PTR_IDX_W'(blk - FIRST_SINGLE);
      end else if (blk < FIRST_TRIPLE) begin
        rel          = blk - FIRST_DOUBLE;
        walk_busy    = 1'b1;
        walk_levels  = LEVEL_ONE_MORE;
        walk_offset  = 15'(rel % PTRS_PER_BLOCK);
        r.kind       = KIND_READ;
        r.address    = it.double_indirect;
        r.word_index = PTR_IDX_W'(rel / PTRS_PER_BLOCK);
      end else if (blk <= LAST_MAPPED) begin
        rel          = blk - FIRST_TRIPLE;
        walk_busy    = 1'b1;
        walk_levels  = LEVEL_TWO_MORE;
        walk_offset  = 15'(rel % (PTRS_PER_BLOCK * PTRS_PER_BLOCK));
        r.kind       = KIND_READ;
        r.address    = it.triple_indirect;
        r.word_index = PTR_IDX_W'(rel / (PTRS_PER_BLOCK * PTRS_PER_BLOCK));
      end else begin
        r.kind = KIND_RANGE;
      end
    end else if (walk_busy) begin
      r.address = it.read_word;
      case (walk_levels)
        LEVEL_LAST: begin
          walk_busy   = 1'b0;
          walk_offset = '0;
          r.kind      = KIND_DONE;
        end
        LEVEL_ONE_MORE: begin
          r.kind       = KIND_READ;
          r.word_index = walk_offset[PTR_IDX_W-1:0];
          walk_levels  = LEVEL_LAST;
          walk_offset  = '0;
        end
        default: begin
          r.kind       = KIND_READ;
          r.word_index = PTR_IDX_W'(walk_offset / PTRS_PER_BLOCK);
          walk_levels  = LEVEL_ONE_MORE;
          walk_offset  = 15'(walk_offset % PTRS_PER_BLOCK);
        end
      endcase
    end
    return r;
  endfunction

  // Build a word with every field random except the command and block number.
  function automatic item_t make_word(input cmd_t cmd, input int blk);
    item_t it;
    it.command     = cmd;
    it.block_index = BLOCK_W'(blk);
    for (int i = 0; i < DIRECT_POINTERS; i++) it.direct[i] = $urandom;
    it.single_indirect = $urandom;
    it.double_indirect = $urandom;
    it.triple_indirect = $urandom;
    it.read_word       = $urandom;
    return it;
  endfunction

  // Offer one word on the slave side; bursts of random length with random
  // gaps between them. Predict the answer at the edge that accepts it.
  task automatic send_word(input item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.command;
    s_axis_tdata  <= {it.read_word, it.triple_indirect, it.double_indirect,
                      it.single_indirect, it.direct, it.block_index};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    answers_due.push_back(map_walk(it));
    words_sent++;
    burst_left--;
  endtask

  task automatic send_start(input int blk);
    send_word(make_word(CMD_START, blk));
  endtask

  task automatic send_pointer(input logic [ADDR_W-1:0] ptr);
    item_t it;
    it = make_word(CMD_WORD, $urandom_range(0, BLOCK_MAX));
    it.read_word = ptr;
    send_word(it);
  endtask

  // Receiver: stretches of always-ready, coin-flip and mostly-stalled, plus
  // a long hold-off on request.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    if (hold_request != 0) begin
      rx_hold = hold_request;
      hold_request = 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(1, 40);
      end
      rx_left--;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each accepted result word with the oldest answer due.
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (answers_due.size() == 0) begin
        $error("unexpected result word: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        want = answers_due.pop_front();
        answers_checked++;
        kind_seen[want.kind]++;
        if (m_axis_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[31:0] !== want.address) begin
          $error("address: expected %h, actual %h", want.address, m_axis_tdata[31:0]);
          error_count++;
        end
        if (m_axis_tdata[36:32] !== want.word_index) begin
          $error("word_index: expected %0d, actual %0d", want.word_index, m_axis_tdata[36:32]);
          error_count++;
        end
        if (m_axis_tdata[39:37] !== 3'b000) begin
          $error("pad: expected 0, actual %b", m_axis_tdata[39:37]);
          error_count++;
        end
      end
    end
  end

  // Hard stop if the run hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** inode_block_map_walker_unit: FAILED **");
    $finish;
  end

  // Direct slots: each of the five pointers, extreme values at both ends.
  task automatic test_direct_slots;
    item_t it;
    for (int b = 0; b < DIRECT_POINTERS; b++) begin
      it = make_word(CMD_START, b);
      if (b == 0) it.direct[0] = '0;
      if (b == DIRECT_POINTERS - 1) it.direct[b] = '1;
      send_word(it);
    end
  endtask

  // Single indirect: first and last entry, then the data pointer word.
  task automatic test_single_indirect;
    send_start(FIRST_SINGLE);
    send_pointer('0);
    send_start(FIRST_DOUBLE - 1);
    send_pointer('1);
  endtask

  // Double indirect: first and last entry, two pointer words each.
  task automatic test_double_indirect;
    send_start(FIRST_DOUBLE);
    send_pointer('1);
    send_pointer('0);
    send_start(FIRST_TRIPLE - 1);
    send_pointer($urandom);
    send_pointer('1);
  endtask

  // Triple indirect: first entry, three pointer words.
  task automatic test_triple_indirect;
    send_start(FIRST_TRIPLE);
    send_pointer('0);
    send_pointer('1);
    send_pointer($urandom);
  endtask

  // Past the triple range, then a word while idle after it.
  task automatic test_out_of_range;
    send_start(LAST_MAPPED + 1);
    send_start(BLOCK_MAX);
    send_pointer($urandom);
  endtask

  // Restart: abandon a triple walk at its last entry mid-way, then a word
  // after the direct answer lands while idle.
  task automatic test_restart;
    send_start(LAST_MAPPED);
    send_pointer($urandom);
    send_start(2);
    send_pointer($urandom);
  endtask

  // Mostly well-formed walks of random depth, some cut short, some stray
  // words and fully random noise.
  task automatic run_random_walks(input int n_words);
    int goal;
    int pick;
    int blk;
    int depth;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      pick  = $urandom_range(0, 10);
      depth = 0;
      case (pick)
        0, 1: blk = $urandom_range(0, FIRST_SINGLE - 1);
        2, 3: begin
          blk = $urandom_range(FIRST_SINGLE, FIRST_DOUBLE - 1);
          depth = 1;
        end
        4, 5: begin
          blk = $urandom_range(FIRST_DOUBLE, FIRST_TRIPLE - 1);
          depth = 2;
        end
        6, 7, 8: begin
          blk = $urandom_range(FIRST_TRIPLE, LAST_MAPPED);
          depth = 3;
        end
        9:       blk = $urandom_range(LAST_MAPPED + 1, BLOCK_MAX);
        default: blk = -1;
      endcase
      if (blk < 0) begin
        send_word(make_word(cmd_t'($urandom_range(0, 1)), $urandom_range(0, BLOCK_MAX)));
      end else begin
        send_start(blk);
        for (int i = 0; i < depth; i++) begin
          // Cut the walk short now and then; the next start restarts it.
          if ($urandom_range(0, 19) == 0) break;
          send_pointer($urandom);
        end
        if ($urandom_range(0, 14) == 0) send_pointer($urandom);
      end
    end
  endtask

  // Receiver holds off long enough for both stages to fill and the slave
  // side to stall while the sender keeps offering walks.
  task automatic test_back_pressure;
    hold_request = HOLD_OFF_CYCLES;
    run_random_walks(40);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_direct_slots();
    test_single_indirect();
    test_double_indirect();
    test_triple_indirect();
    test_out_of_range();
    test_restart();
    test_back_pressure();
    run_random_walks(RANDOM_WORDS);

    s_axis_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (answers_due.size() != 0) error_count++;

    $display("Run covered %0d words in, %0d answers checked, %0d mismatches.",
             words_sent, answers_checked, error_count);
    $display("Answers by kind: read %0d, done %0d, out of range %0d, not busy %0d.",
             kind_seen[KIND_READ], kind_seen[KIND_DONE], kind_seen[KIND_RANGE],
             kind_seen[KIND_IDLE]);
    if (error_count == 0) begin
      $display("** inode_block_map_walker_unit: PASSED **");
    end else begin
      $display("** inode_block_map_walker_unit: FAILED **");
    end
    $finish;
  end

endmodule
